// ===== rtl/core/utf8dec_pkg.sv =====
package utf8dec_pkg;

  // Field widths fixed by the byte stream and the result format.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned PartW  = 10;

  // Defaults for the top-level parameters.
  localparam int unsigned DefaultLimit = 65535;
  localparam int unsigned DefaultQueueDepth = 2;

  // Result item kind.
  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_END  = 1'b1
  } kind_e;

  // End report status.
  typedef enum logic {
    STATUS_OK  = 1'b0,
    STATUS_BAD = 1'b1
  } status_e;

  // One unit of work handed from the front to the back. A job carries a
  // decoded character, an end report, or a character followed by an end report.
  typedef struct packed {
    logic                has_char;
    logic                has_end;
    status_e             status;
    logic [CodeW-1:0]    code_point;
    logic [CountW-1:0]   char_count;
  } job_t;

endpackage

// ===== rtl/core/utf8_to_ucs2_stream_decoder_top.sv =====
// Channel   Handshake                 Payload
// input     in_valid_i / in_ready_o   in_byte_i
// result    out_valid_o / out_ready_i kind_o, code_point_o, status_o, char_count_o, last_o
// config    cfg_we_i                  cfg_wdata_i
//
// One byte is taken per cycle while the job queue has a free slot; the
// front classifies it and updates the sequence state in that same cycle.
// A queued job reaches the output through the queue storage and then the
// output register. A byte that yields a character plus an end report gives
// two result items from the single output register, the character first.
// Reset clears all control state and the character limit; a stalled output
// fills the queue and then holds in_ready_o low.
module utf8_to_ucs2_stream_decoder_top import utf8dec_pkg::*; #(
  parameter int unsigned DEFAULT_LIMIT = DefaultLimit,
  parameter int unsigned QUEUE_DEPTH   = DefaultQueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  in_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              kind_o,
  output logic [CodeW-1:0]  code_point_o,
  output logic              status_o,
  output logic [CountW-1:0] char_count_o,
  output logic              last_o
);

  logic push, pop, full, empty;
  job_t job_in, job_out;

  // Front: byte classification and sequence state.
  utf8dec_front #(
    .DEFAULT_LIMIT(DEFAULT_LIMIT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .queue_full_i (full),
    .push_o       (push),
    .job_o        (job_in)
  );

  // Job queue between the two halves.
  utf8dec_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (empty)
  );

  // Back: result sequencing and output register.
  utf8dec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .job_i        (job_out),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .code_point_o (code_point_o),
    .status_o     (status_o),
    .char_count_o (char_count_o),
    .last_o       (last_o)
  );

endmodule

// ===== rtl/core/utf8dec_front.sv =====
module utf8dec_front import utf8dec_pkg::*; #(
  parameter int unsigned DEFAULT_LIMIT = DefaultLimit
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  in_byte_i,
  input  logic              queue_full_i,
  output logic              push_o,
  output job_t              job_o
);

  logic [CountW-1:0] max_chars_q;
  logic              discard_q, discard_d;
  logic [1:0]        pend_q, pend_d;
  logic [PartW-1:0]  part_q, part_d;
  logic [CountW-1:0] count_q, count_d;

  logic              accept;
  logic [CountW-1:0] limit;
  logic [CountW-1:0] count_inc;
  logic [CodeW-1:0]  acc;
  logic [1:0]        pend_dec;
  logic [CodeW-1:0]  char_cp;
  logic              char_emit;

  // The front takes a byte whenever the queue has a free slot.
  assign in_ready_o = ~queue_full_i;
  assign accept     = in_valid_i & in_ready_o;

  // Character limit; zero selects the default.
  assign limit     = (max_chars_q == '0) ? CountW'(DEFAULT_LIMIT) : max_chars_q;
  assign count_inc = count_q + CountW'(1);
  assign acc       = {part_q, in_byte_i[5:0]};
  assign pend_dec  = pend_q - 2'd1;

  // Classify the byte and update the sequence state.
  always_comb begin
    discard_d = discard_q;
    pend_d    = pend_q;
    part_d    = part_q;
    count_d   = count_q;
    push_o    = 1'b0;
    job_o     = '{has_char: 1'b0, has_end: 1'b0, status: STATUS_OK,
                  code_point: '0, char_count: '0};
    char_emit = 1'b0;
    char_cp   = '0;

    if (discard_q) begin
      if (in_byte_i == '0) begin
        discard_d = 1'b0;
        pend_d    = '0;
        part_d    = '0;
        count_d   = '0;
      end
    end else if (pend_q != '0) begin
      if (in_byte_i[7:6] != 2'b10) begin
        // Missing continuation byte.
        push_o           = 1'b1;
        job_o.has_end    = 1'b1;
        job_o.status     = STATUS_BAD;
        job_o.char_count = count_q;
        pend_d           = '0;
        part_d           = '0;
        count_d          = '0;
        discard_d        = (in_byte_i != '0);
      end else begin
        pend_d = pend_dec;
        if (pend_dec != '0) begin
          part_d = acc[PartW-1:0];
        end else begin
          part_d    = '0;
          char_emit = 1'b1;
          char_cp   = acc;
        end
      end
    end else if (in_byte_i == '0) begin
      // Terminator ends the string with success.
      push_o           = 1'b1;
      job_o.has_end    = 1'b1;
      job_o.char_count = count_q;
      pend_d           = '0;
      part_d           = '0;
      count_d          = '0;
    end else if (in_byte_i[7] == 1'b0) begin
      char_emit = 1'b1;
      char_cp   = {8'h00, in_byte_i};
    end else if (in_byte_i[7:5] == 3'b110) begin
      part_d = {5'b0, in_byte_i[4:0]};
      pend_d = 2'd1;
    end else if (in_byte_i[7:4] == 4'b1110) begin
      part_d = {6'b0, in_byte_i[3:0]};
      pend_d = 2'd2;
    end else begin
      // Stray continuation or a lead byte of four bytes or more.
      push_o           = 1'b1;
      job_o.has_end    = 1'b1;
      job_o.status     = STATUS_BAD;
      job_o.char_count = count_q;
      pend_d           = '0;
      part_d           = '0;
      count_d          = '0;
      discard_d        = 1'b1;
    end

    // A decoded character counts and may reach the limit.
    if (char_emit) begin
      push_o           = 1'b1;
      job_o.has_char   = 1'b1;
      job_o.code_point = char_cp;
      count_d          = count_inc;
      if (count_inc >= limit) begin
        job_o.has_end    = 1'b1;
        job_o.char_count = count_inc;
        pend_d           = '0;
        part_d           = '0;
        count_d          = '0;
        discard_d        = 1'b1;
      end
    end

    if (!accept) begin
      push_o = 1'b0;
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q <= '0;
    end else if (cfg_we_i) begin
      max_chars_q <= cfg_wdata_i;
    end
  end

  // Sequence state advances on each accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      discard_q <= 1'b0;
      pend_q    <= '0;
      part_q    <= '0;
      count_q   <= '0;
    end else if (accept) begin
      discard_q <= discard_d;
      pend_q    <= pend_d;
      part_q    <= part_d;
      count_q   <= count_d;
    end
  end

endmodule

// ===== rtl/core/utf8dec_queue.sv =====
module utf8dec_queue import utf8dec_pkg::*; #(
  parameter int unsigned DEPTH = DefaultQueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Storage for queued jobs.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/utf8dec_back.sv =====
module utf8dec_back import utf8dec_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  job_t              job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              kind_o,
  output logic [CodeW-1:0]  code_point_o,
  output logic              status_o,
  output logic [CountW-1:0] char_count_o,
  output logic              last_o
);

  logic              out_valid_q;
  logic              phase_q, phase_d;
  logic              load;
  kind_e             kind_q, kind_d;
  logic [CodeW-1:0]  code_q, code_d;
  status_e           status_q, status_d;
  logic [CountW-1:0] count_q, count_d;
  logic              last_q, last_d;

  // The output register takes a new item when it is empty or being drained.
  assign load = ~empty_i & (~out_valid_q | out_ready_i);

  // Expand the head job into one or two result items.
  always_comb begin
    phase_d  = phase_q;
    pop_o    = 1'b0;
    kind_d   = KIND_END;
    code_d   = '0;
    status_d = job_i.status;
    count_d  = job_i.char_count;
    last_d   = 1'b1;
    if (job_i.has_char && !phase_q) begin
      kind_d   = KIND_CHAR;
      code_d   = job_i.code_point;
      status_d = STATUS_OK;
      count_d  = '0;
      last_d   = ~job_i.has_end;
      if (job_i.has_end) begin
        phase_d = 1'b1;
      end else begin
        pop_o = load;
      end
    end else begin
      phase_d = 1'b0;
      pop_o   = load;
    end
  end

  // Control state of the output stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind_d;
      code_q   <= code_d;
      status_q <= status_d;
      count_q  <= count_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign code_point_o = code_q;
  assign status_o     = status_q;
  assign char_count_o = count_q;
  assign last_o       = last_q;

endmodule

// ===== dv/utf8_to_ucs2_stream_decoder_top_tb.sv =====
`timescale 1ns / 100ps

module utf8_to_ucs2_stream_decoder_top_tb;
  import utf8dec_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned RandomBytes = 1950;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxReports = 40;

  // One result item as it leaves the decoder.
  typedef struct packed {
    kind_e               kind;
    logic [CodeW-1:0]    code_point;
    status_e             status;
    logic [CountW-1:0]   char_count;
    logic                last;
  } result_t;

  // One input byte, with its results typed in where they are fixed by hand.
  typedef struct {
    logic [ByteW-1:0] data;
    bit               typed;
    int unsigned      n;
    result_t          r0;
    result_t          r1;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [ByteW-1:0]  in_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              kind_o;
  logic [CodeW-1:0]  code_point_o;
  logic              status_o;
  logic [CountW-1:0] char_count_o;
  logic              last_o;

  // Decoder state as the predictor sees it; reset values are all zero.
  logic [PartW-1:0]  pend_code = '0;
  logic [1:0]        pend_bytes = '0;
  logic [CountW-1:0] str_chars = '0;
  logic              skipping = 1'b0;
  logic [CountW-1:0] char_limit = '0;

  result_t     decode_q[$];
  stim_row_t   in_flight_q[$];
  stim_row_t   dir_rows[$];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned bytes_sent = 0;

  utf8_to_ucs2_stream_decoder_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .code_point_o (code_point_o),
    .status_o     (status_o),
    .char_count_o (char_count_o),
    .last_o       (last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic result_t char_res(input logic [CodeW-1:0] cp, input logic lst);
    char_res = '{kind: KIND_CHAR, code_point: cp, status: STATUS_OK,
                 char_count: '0, last: lst};
  endfunction

  function automatic result_t end_res(input status_e st, input logic [CountW-1:0] cnt);
    end_res = '{kind: KIND_END, code_point: '0, status: st,
                char_count: cnt, last: 1'b1};
  endfunction

  task automatic clear_string();
    pend_code = '0;
    pend_bytes = '0;
    str_chars = '0;
  endtask

  // A malformed byte ends the string; a zero byte needs no discarding after it.
  task automatic string_error(input logic [ByteW-1:0] b, inout int unsigned n,
                              inout result_t r0);
    r0 = end_res(STATUS_BAD, str_chars);
    n = 1;
    clear_string();
    skipping = (b != '0);
  endtask

  // Count one decoded character and close the string when the limit is hit.
  task automatic count_char(input logic [CodeW-1:0] cp, inout int unsigned n,
                            inout result_t r0, inout result_t r1);
    int unsigned lim;
    lim = (char_limit == '0) ? DefaultLimit : char_limit;
    str_chars = str_chars + 1'b1;
    if (str_chars >= lim) begin
      r0 = char_res(cp, 1'b0);
      r1 = end_res(STATUS_OK, str_chars);
      n = 2;
      clear_string();
      skipping = 1'b1;
    end else begin
      r0 = char_res(cp, 1'b1);
      n = 1;
    end
  endtask

  // Advance the decoder state by one byte and return the results it causes.
  task automatic decode_byte(input logic [ByteW-1:0] b, output int unsigned n,
                             output result_t r0, output result_t r1);
    logic [CodeW-1:0] acc;
    n = 0;
    r0 = '0;
    r1 = '0;
    if (skipping) begin
      if (b == '0) begin
        skipping = 1'b0;
        clear_string();
      end
    end else if (pend_bytes != '0) begin
      if (b[7:6] != 2'b10) begin
        string_error(b, n, r0);
      end else begin
        acc = {pend_code, b[5:0]};
        pend_bytes = pend_bytes - 1'b1;
        if (pend_bytes != '0) begin
          pend_code = acc[PartW-1:0];
        end else begin
          pend_code = '0;
          count_char(acc, n, r0, r1);
        end
      end
    end else if (b == '0) begin
      r0 = end_res(STATUS_OK, str_chars);
      n = 1;
      clear_string();
    end else if (b < 8'h80) begin
      count_char({8'h00, b}, n, r0, r1);
    end else if (b[7:5] == 3'b110) begin
      pend_code = {5'b0, b[4:0]};
      pend_bytes = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      pend_code = {6'b0, b[3:0]};
      pend_bytes = 2'd2;
    end else begin
      string_error(b, n, r0);
    end
  endtask

  task automatic field_mismatch(input string name, input int unsigned want,
                                input int unsigned got);
    errors++;
    if (errors <= MaxReports) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  // Receiver side: stall at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Track register writes, check each result item, and predict each input item.
  always @(posedge clk_i) begin
    result_t     want;
    stim_row_t   row;
    int unsigned n;
    result_t     r0;
    result_t     r1;
    if (rst_ni) begin
      if (cfg_we_i) begin
        char_limit = cfg_wdata_i;
      end
      if (out_valid_o && out_ready_i) begin
        if (decode_q.size() == 0) begin
          errors++;
          if (errors <= MaxReports) begin
            $error("result item with nothing outstanding: kind %0d code 0x%0h",
                   kind_o, code_point_o);
          end
        end else begin
          want = decode_q.pop_front();
          if (kind_o !== want.kind) field_mismatch("kind", want.kind, kind_o);
          if (code_point_o !== want.code_point)
            field_mismatch("code_point", want.code_point, code_point_o);
          if (status_o !== want.status) field_mismatch("status", want.status, status_o);
          if (char_count_o !== want.char_count)
            field_mismatch("char_count", want.char_count, char_count_o);
          if (last_o !== want.last) field_mismatch("last", want.last, last_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        row = in_flight_q.pop_front();
        decode_byte(in_byte_i, n, r0, r1);
        if (row.typed) begin
          n = row.n;
          r0 = row.r0;
          r1 = row.r1;
        end
        if (n > 0) decode_q.push_back(r0);
        if (n > 1) decode_q.push_back(r1);
      end
    end
  end

  // Sender side: an optional gap, then hold the item until it is taken.
  task automatic send_byte(input stim_row_t row);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_flight_q.push_back(row);
    in_valid_i <= 1'b1;
    in_byte_i <= row.data;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_plain(input logic [ByteW-1:0] b);
    stim_row_t row;
    row = '{data: b, typed: 1'b0, n: 0, r0: '0, r1: '0};
    send_byte(row);
  endtask

  task automatic add_typed(input logic [ByteW-1:0] b, input int unsigned n,
                           input result_t r0, input result_t r1);
    dir_rows.push_back('{data: b, typed: 1'b1, n: n, r0: r0, r1: r1});
  endtask

  task automatic add_plain(input logic [ByteW-1:0] b);
    dir_rows.push_back('{data: b, typed: 1'b0, n: 0, r0: '0, r1: '0});
  endtask

  // Stop sending and wait for every outstanding result, plus a short settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (decode_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [CountW-1:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random token: mostly well-formed characters, some terminators,
  // noise bytes and sequences cut short by a non-continuation byte.
  task automatic send_token();
    int unsigned pick;
    int unsigned bad;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_plain(8'($urandom_range(1, 127)));
    end else if (pick < 60) begin
      send_plain(8'($urandom_range(8'hC0, 8'hDF)));
      send_plain(8'($urandom_range(8'h80, 8'hBF)));
    end else if (pick < 75) begin
      send_plain(8'($urandom_range(8'hE0, 8'hEF)));
      send_plain(8'($urandom_range(8'h80, 8'hBF)));
      send_plain(8'($urandom_range(8'h80, 8'hBF)));
    end else if (pick < 82) begin
      send_plain(8'h00);
    end else if (pick < 90) begin
      send_plain(8'($urandom_range(0, 255)));
    end else begin
      send_plain(8'($urandom_range(8'hC0, 8'hEF)));
      bad = $urandom_range(0, 191);
      if (bad >= 128) bad += 64;
      send_plain(8'(bad));
    end
  endtask

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned idle_tbl[NumPhases];
    int unsigned stall_tbl[NumPhases];
    int unsigned limit_tbl[NumPhases];
    int unsigned goal;
    idle_tbl = '{0, 64, 0, 33, 0, 64, 0, 33};
    stall_tbl = '{0, 0, 64, 33, 0, 0, 64, 33};
    limit_tbl = '{3, 1, 65535, 2, 0, 7, 1, 40};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed bytes: terminator after reset, ASCII bytes up to 0x7F, the
    // overlong and widest two- and three-byte values, a stray continuation,
    // a bad lead, and sequences broken by a zero byte or by an ASCII byte.
    add_typed(8'h00, 1, end_res(STATUS_OK, 16'd0), '0);
    add_typed(8'h41, 1, char_res(16'h0041, 1'b1), '0);
    add_typed(8'h7F, 1, char_res(16'h007F, 1'b1), '0);
    add_typed(8'hC0, 0, '0, '0);
    add_typed(8'h80, 1, char_res(16'h0000, 1'b1), '0);
    add_plain(8'hDF);
    add_plain(8'hBF);
    add_plain(8'hE0);
    add_plain(8'h80);
    add_plain(8'h80);
    add_plain(8'hEF);
    add_plain(8'hBF);
    add_plain(8'hBF);
    add_plain(8'h00);
    add_typed(8'h80, 1, end_res(STATUS_BAD, 16'd0), '0);
    add_typed(8'h41, 0, '0, '0);
    add_typed(8'h00, 0, '0, '0);
    add_typed(8'hF0, 1, end_res(STATUS_BAD, 16'd0), '0);
    add_typed(8'h00, 0, '0, '0);
    add_typed(8'hC3, 0, '0, '0);
    add_typed(8'h00, 1, end_res(STATUS_BAD, 16'd0), '0);
    add_plain(8'hE2);
    add_plain(8'h82);
    add_typed(8'h41, 1, end_res(STATUS_BAD, 16'd0), '0);
    add_typed(8'h00, 0, '0, '0);
    foreach (dir_rows[i]) send_byte(dir_rows[i]);

    // Random phases, each with its own limit and idling and stalling pattern.
    for (int p = 0; p < NumPhases; p++) begin
      set_limit(CountW'(limit_tbl[p]));
      idle_pct = idle_tbl[p];
      stall_pct = stall_tbl[p];
      goal = bytes_sent + RandomBytes / NumPhases;
      while (bytes_sent < goal) send_token();
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (decode_q.size() != 0) begin
      errors++;
      $error("%0d result items never arrived", decode_q.size());
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
